>>> src/tps_pkg.sv
// Package for the tridiagonal precision sampler: payload types, sizes,
// status codes and shared Q16.16 helpers. No dependencies.
`timescale 1ns / 1ps
package tps_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PIVOT    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] diag_value;
    logic signed [31:0] rhs_value;
    logic signed [31:0] noise_value;
    logic               last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [5:0]         sample_index;
    logic               last_out;
    logic [1:0]         status;
  } out_req_t;

  // saturate a 34-bit sum/difference to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7fffffff) r = Q_MAX;
    else if (v < -34'sh0_80000000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/tps_mul.sv
// Bit-serial Q16.16 multiplier: one shift-add per cycle, floor rounding,
// saturation. Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] y
);
  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic [31:0] amag, bmag;
  logic signed [64:0] prod;
  logic signed [48:0] sh;

  assign amag = a[31] ? 32'(-a) : 32'(a);
  assign bmag = b[31] ? 32'(-b) : 32'(b);
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign sh   = 49'(prod >>> 16);

  always_comb begin
    mcand_nxt = mcand_r; mplier_nxt = mplier_r; acc_nxt = acc_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0; y_nxt = y_r;
    if (go) begin
      mcand_nxt = amag; mplier_nxt = bmag; acc_nxt = '0;
      neg_nxt = a[31] ^ b[31]; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (sh > 49'sh0_7fff_ffff) y_nxt = tps_pkg::Q_MAX;
        else if (sh < -49'sh0_8000_0000) y_nxt = tps_pkg::Q_MIN;
        else y_nxt = sh[31:0];
      end else begin
        if (mplier_r[0]) acc_nxt = acc_r + ({32'd0, mcand_r} << cnt_r[4:0]);
        mplier_nxt = mplier_r >> 1;
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    mcand_r <= mcand_nxt; mplier_r <= mplier_nxt; acc_r <= acc_nxt;
    neg_r <= neg_nxt; cnt_r <= cnt_nxt; y_r <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;
endmodule

>>> src/tps_div.sv
// Restoring divider for Q16.16 (a<<16)/b, one quotient bit per cycle,
// truncation toward zero with saturation. Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] y
);
  logic [47:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic        anz_r, anz_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_r[31:0], num_r[47]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; neg_nxt = neg_r;
    zero_nxt = zero_r; anz_nxt = anz_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0; y_nxt = y_r;
    if (go) begin
      num_nxt  = {(a[31] ? 32'(-a) : 32'(a)), 16'd0};
      den_nxt  = b[31] ? 32'(-b) : 32'(b);
      rem_nxt  = '0;
      neg_nxt  = a[31] ^ b[31];
      zero_nxt = (b == 32'sd0);
      anz_nxt  = (a != 32'sd0);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd48) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (zero_r) begin
          if (!anz_r) y_nxt = '0;
          else y_nxt = neg_r ? tps_pkg::Q_MIN : tps_pkg::Q_MAX;
        end else if (neg_r) begin
          // quotient bits held in num_r
          if (num_r > 48'h0000_8000_0000) y_nxt = tps_pkg::Q_MIN;
          else y_nxt = 32'(-num_r[31:0]);
        end else begin
          if (num_r > 48'h0000_7fff_ffff) y_nxt = tps_pkg::Q_MAX;
          else y_nxt = num_r[31:0];
        end
      end else begin
        if (!diff[32]) begin
          rem_nxt = diff;
          num_nxt = {num_r[46:0], 1'b1};
        end else begin
          rem_nxt = trial;
          num_nxt = {num_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
    zero_r <= zero_nxt; anz_r <= anz_nxt; cnt_r <= cnt_nxt; y_r <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;
endmodule

>>> src/tps_sqrt.sv
// Digit-by-digit integer square root of x<<16 (x > 0), two radicand bits
// per cycle. Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] y
);
  logic [47:0] rad_r, rad_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [23:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [25:0] trial;
  logic [25:0] test;

  assign trial = {rem_r[23:0], rad_r[47:46]};
  assign test  = {root_r, 2'b01};

  always_comb begin
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (go) begin
      rad_nxt = {x[31:0], 16'd0};
      rem_nxt = '0; root_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
      if (trial >= test) begin
        rem_nxt  = trial - test;
        root_nxt = {root_r[22:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        root_nxt = {root_r[22:0], 1'b0};
      end
      rad_nxt = {rad_r[45:0], 2'b00};
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt; cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign y    = {8'd0, root_r};
endmodule

>>> src/tridiagonal_precision_sampler.sv
// Top level: sequencer over shared serial mul, div and sqrt units plus
// the three factor stores. Depends on tps_pkg, tps_mul, tps_div, tps_sqrt.
// Each item without last runs two divides, two multiplies, a square root
// (skipped on a non-positive pivot) and sequencing. The first item of a
// sequence runs one divide, no multiply. A last item then adds the backward
// pass: a multiply and a divide per stored element, a divide alone for the
// top one, with one result per element. Synchronous reset clears count,
// status and sequencer; stores are not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
module tridiagonal_precision_sampler (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  tps_pkg::in_req_t         in_req,
  output logic                     out_valid,
  output tps_pkg::out_req_t        out_req,
  input  logic                     cfg_we,
  input  logic signed [31:0]       cfg_wdata
);
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_OFF   = 14'b00000000000010,
    S_OSQ   = 14'b00000000000100,
    S_RAD   = 14'b00000000001000,
    S_SQRT  = 14'b00000000010000,
    S_HMUL  = 14'b00000000100000,
    S_HDIV  = 14'b00000001000000,
    S_STORE = 14'b00000010000000,
    S_BRD   = 14'b00000100000000,
    S_BWAIT = 14'b00001000000000,
    S_BMUL  = 14'b00010000000000,
    S_BDIV  = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_END   = 14'b10000000000000
  } state_t;

  localparam int IW = tps_pkg::IDX_W;
  localparam int CW = tps_pkg::CNT_W;

  state_t state_r, state_nxt;
  logic signed [31:0] coup_r;
  tps_pkg::in_req_t item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [31:0] prev_l_r, prev_l_nxt, prev_h_r, prev_h_nxt;
  logic [1:0] err_r, err_nxt;
  logic signed [31:0] off_r, off_nxt, rad_r, rad_nxt, l_r, l_nxt, h_r, h_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic first_r, first_nxt;
  logic out_valid_r, out_valid_nxt;

  logic signed [31:0] ld_mem [tps_pkg::MAX_LEN];
  logic signed [31:0] lo_mem [tps_pkg::MAX_LEN];
  logic signed [31:0] fr_mem [tps_pkg::MAX_LEN];
  logic signed [31:0] ld_q, lo_q, fr_q;

  logic mul_go, div_go, sq_go, mul_done, div_done, sq_done;
  logic signed [31:0] mul_a, mul_b, div_a, div_b, mul_y, div_y, sq_y;
  logic wr_lo, wr_main;
  logic [IW-1:0] cur_idx;

  tps_mul u_mul (.clk, .rst_n, .go(mul_go), .a(mul_a), .b(mul_b),
                 .done(mul_done), .y(mul_y));
  tps_div u_div (.clk, .rst_n, .go(div_go), .a(div_a), .b(div_b),
                 .done(div_done), .y(div_y));
  tps_sqrt u_sqrt (.clk, .rst_n, .go(sq_go), .x(rad_r), .done(sq_done), .y(sq_y));

  assign cur_idx = count_r[IW-1:0];
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; prev_l_nxt = prev_l_r;
    prev_h_nxt = prev_h_r; err_nxt = err_r; off_nxt = off_r; rad_nxt = rad_r;
    l_nxt = l_r; h_nxt = h_r; x_nxt = x_r; j_nxt = j_r; first_nxt = first_r;
    out_valid_nxt = 1'b0;
    mul_go = 1'b0; div_go = 1'b0; sq_go = 1'b0;
    mul_a = off_r; mul_b = off_r; div_a = coup_r; div_b = prev_l_r;
    wr_lo = 1'b0; wr_main = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count_r == CW'(tps_pkg::MAX_LEN)) begin
            if (err_nxt == tps_pkg::ST_OK) err_nxt = tps_pkg::ST_TOO_LONG;
            state_nxt = S_END;
          end else if (count_r == '0) begin
            rad_nxt = in_req.diag_value;
            state_nxt = S_RAD;
          end else begin
            div_go = 1'b1; state_nxt = S_OFF;
          end
        end
      end
      S_OFF: if (div_done) begin
        off_nxt = div_y; wr_lo = 1'b1;
        mul_a = div_y; mul_b = div_y; mul_go = 1'b1; state_nxt = S_OSQ;
      end
      S_OSQ: if (mul_done) begin
        rad_nxt = tps_pkg::sat34(34'(item_r.diag_value) - 34'(mul_y));
        state_nxt = S_RAD;
      end
      S_RAD: begin
        if (count_r == '0) rad_nxt = item_r.diag_value;
        state_nxt = S_SQRT;
        if ((count_r == '0 ? item_r.diag_value : rad_r) <= 32'sd0) begin
          l_nxt = '0;
          if (err_r == tps_pkg::ST_OK) err_nxt = tps_pkg::ST_PIVOT;
          state_nxt = S_HMUL;
        end else begin
          sq_go = 1'b1;
        end
      end
      S_SQRT: if (sq_done) begin
        l_nxt = sq_y; state_nxt = S_HMUL;
      end
      S_HMUL: begin
        if (count_r == '0) begin
          div_a = item_r.rhs_value; div_b = l_r; div_go = 1'b1; state_nxt = S_HDIV;
        end else if (!first_r) begin
          mul_a = off_r; mul_b = prev_h_r; mul_go = 1'b1; first_nxt = 1'b1;
        end else if (mul_done) begin
          div_a = tps_pkg::sat34(34'(item_r.rhs_value) - 34'(mul_y));
          div_b = l_r; div_go = 1'b1; first_nxt = 1'b0; state_nxt = S_HDIV;
        end
      end
      S_HDIV: if (div_done) begin
        h_nxt = div_y; state_nxt = S_STORE;
      end
      S_STORE: begin
        wr_main = 1'b1;
        prev_l_nxt = l_r; prev_h_nxt = h_r;
        count_nxt = count_r + CW'(1);
        if (item_r.last_in) begin
          j_nxt = cur_idx; first_nxt = 1'b1; state_nxt = S_BRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BRD: state_nxt = S_BWAIT;
      S_BWAIT: begin
        // store reads registered; start the multiply or divide
        if (first_r) begin
          div_a = fr_q; div_b = ld_q; div_go = 1'b1; state_nxt = S_BDIV;
        end else begin
          mul_a = lo_q; mul_b = x_r; mul_go = 1'b1; state_nxt = S_BMUL;
        end
      end
      S_BMUL: if (mul_done) begin
        div_a = tps_pkg::sat34(34'(fr_q) - 34'(mul_y));
        div_b = ld_q; div_go = 1'b1; state_nxt = S_BDIV;
      end
      S_BDIV: if (div_done) begin
        x_nxt = div_y; out_valid_nxt = 1'b1; state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (j_r == '0) begin
          // first_r marks the backward pass as finished
          first_nxt = 1'b1; state_nxt = S_END;
        end else begin
          first_nxt = 1'b0; j_nxt = j_r - IW'(1); state_nxt = S_BRD;
        end
      end
      S_END: begin
        if (item_r.last_in && !first_r) begin
          // dropped last item on a full store: backward pass over all entries
          j_nxt = IW'(tps_pkg::MAX_LEN - 1); first_nxt = 1'b1; state_nxt = S_BRD;
        end else begin
          state_nxt = S_IDLE; first_nxt = 1'b0;
          if (item_r.last_in) begin
            count_nxt = '0; prev_l_nxt = '0; prev_h_nxt = '0;
            err_nxt = tps_pkg::ST_OK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; err_r <= '0; prev_l_r <= '0;
      prev_h_r <= '0; coup_r <= '0; out_valid_r <= 1'b0; first_r <= 1'b0;
    end else begin
      if (cfg_we) coup_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
      state_r <= state_nxt; count_r <= count_nxt; err_r <= err_nxt;
      prev_l_r <= prev_l_nxt; prev_h_r <= prev_h_nxt; first_r <= first_nxt;
      j_r <= j_nxt;
    end
    if (start && !busy) item_r <= in_req;
    off_r <= off_nxt; rad_r <= rad_nxt; l_r <= l_nxt; h_r <= h_nxt; x_r <= x_nxt;
  end

  // factor stores
  always_ff @(posedge clk) begin
    if (wr_lo) lo_mem[cur_idx - IW'(1)] <= off_nxt;
    if (wr_main) begin
      ld_mem[cur_idx] <= l_r;
      fr_mem[cur_idx] <= tps_pkg::sat34(34'(h_r) + 34'(item_r.noise_value));
    end
    ld_q <= ld_mem[j_r];
    lo_q <= lo_mem[j_r];
    fr_q <= fr_mem[j_r];
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_req.sample_value = x_r;
    out_req.sample_index = 6'(j_r);
    out_req.last_out     = (j_r == '0);
    out_req.status       = err_r;
  end

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(tps_pkg::MAX_LEN)) else $error("count overflow");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != 2'd3) else $error("bad status");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mul_go, div_go, sq_go}) <= 1) else $error("unit conflict");
endmodule
